@@ hw/rtl/gsps_pkg.sv @@
// shared types, codes and neighbor tables for the grid shortest path search unit
// no dependencies; imported by gsps_ctrl, gsps_dp and the top level
package gsps_pkg;

   // default store size
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   // fixed field widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int EXT_W      = 9;
   localparam int DIST_OUT_W = 12;

   // neighbor counter codes
   localparam logic [3:0] K_SELF = 4'd4;
   localparam logic [3:0] K_LAST = 4'd8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_W   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_H   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_C  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_R  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_C   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_R   = 3'd6;

   typedef enum logic [1:0] {
      REQ_WALL = 2'd0,
      REQ_RUN  = 2'd1,
      REQ_READ = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_PATH  = 2'd1,
      ST_BAD_GEOM = 2'd2,
      ST_NO_TRACE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_GEOM,
      RES_NOREAD,
      RES_NOPATH,
      RES_RUNOK,
      RES_PATH,
      RES_PATH_LAST
   } res_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLR,
      S_SEED,
      S_POP,
      S_POP_W,
      S_NB_ADDR,
      S_NB_CHK,
      S_RD_CUR,
      S_RD_CUR_W,
      S_RNB_ADDR,
      S_RNB_CHK,
      S_RD_END,
      S_OUT
   } state_type;

   typedef struct packed {
      logic    wclr_step;
      logic    wall_wr;
      logic    run_begin;
      logic    clr_step;
      logic    seed;
      logic    q_rd;
      logic    pop_latch;
      logic    trace_set;
      logic    nb_addr;
      logic    nb_chk_run;
      logic    nb_chk_rd;
      logic    rd_cur;
      logic    rd_latch;
      logic    trace_clr;
      logic    rd_end;
      logic    rsp_load;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic geom_ok;
      logic trace_valid;
      logic q_empty;
      logic pop_is_goal;
      logic nb_last;
      logic cursor_is_start;
      logic rsp_free;
   } stat_type;

   // column offset of neighbor k, two-bit signed
   function automatic logic [1:0] nb_dx(input logic [3:0] k);
      logic [1:0] d;
      unique case (k)
         4'd0, 4'd1, 4'd2: d = 2'b11;
         4'd6, 4'd7, 4'd8: d = 2'b01;
         default:          d = 2'b00;
      endcase
      return d;
   endfunction

   // row offset of neighbor k, two-bit signed
   function automatic logic [1:0] nb_dy(input logic [3:0] k);
      logic [1:0] d;
      unique case (k)
         4'd0, 4'd3, 4'd6: d = 2'b11;
         4'd2, 4'd5, 4'd8: d = 2'b01;
         default:          d = 2'b00;
      endcase
      return d;
   endfunction

endpackage

@@ hw/rtl/gsps_ctrl.sv @@
// sequencer for the grid shortest path search unit
// depends on gsps_pkg; drives gsps_dp through cmd_type and reads stat_type
module gsps_ctrl import gsps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   res_type   res_ff, res_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         res_ff   <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      cmd        = '0;
      cmd.res    = res_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_INIT: begin
            cmd.wclr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_kind_type'(req_tuser))
                  REQ_WALL: begin
                     cmd.wall_wr = 1'b1;
                     res_in      = RES_ZERO;
                     state_in    = S_OUT;
                  end
                  REQ_RUN: begin
                     cmd.run_begin = 1'b1;
                     if (stat.geom_ok) begin
                        state_in = S_CLR;
                     end else begin
                        res_in   = RES_GEOM;
                        state_in = S_OUT;
                     end
                  end
                  REQ_READ: begin
                     if (stat.trace_valid) begin
                        state_in = S_RD_CUR;
                     end else begin
                        res_in   = RES_NOREAD;
                        state_in = S_OUT;
                     end
                  end
                  REQ_NONE: begin
                     res_in   = RES_ZERO;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_SEED;
         end
         S_SEED: begin
            cmd.seed = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (stat.q_empty) begin
               res_in   = RES_NOPATH;
               state_in = S_OUT;
            end else begin
               cmd.q_rd = 1'b1;
               state_in = S_POP_W;
            end
         end
         S_POP_W: begin
            cmd.pop_latch = 1'b1;
            if (stat.pop_is_goal) begin
               cmd.trace_set = 1'b1;
               res_in        = RES_RUNOK;
               state_in      = S_OUT;
            end else begin
               state_in = S_NB_ADDR;
            end
         end
         S_NB_ADDR: begin
            cmd.nb_addr = 1'b1;
            state_in    = S_NB_CHK;
         end
         S_NB_CHK: begin
            cmd.nb_chk_run = 1'b1;
            state_in       = stat.nb_last ? S_POP : S_NB_ADDR;
         end
         S_RD_CUR: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_RD_CUR_W;
         end
         S_RD_CUR_W: begin
            cmd.rd_latch = 1'b1;
            if (stat.cursor_is_start) begin
               cmd.trace_clr = 1'b1;
               res_in        = RES_PATH_LAST;
               state_in      = S_OUT;
            end else begin
               state_in = S_RNB_ADDR;
            end
         end
         S_RNB_ADDR: begin
            cmd.nb_addr = 1'b1;
            state_in    = S_RNB_CHK;
         end
         S_RNB_CHK: begin
            cmd.nb_chk_rd = 1'b1;
            state_in      = stat.nb_last ? S_RD_END : S_RNB_ADDR;
         end
         S_RD_END: begin
            cmd.rd_end = 1'b1;
            res_in     = RES_PATH;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/gsps_dp.sv @@
// datapath of the grid shortest path search unit: stores, queue, registers, result
// depends on gsps_pkg; commanded by gsps_ctrl
module gsps_dp import gsps_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [5:0]            req_col,
   input  logic [5:0]            req_row,
   input  logic                  req_wall,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [DIST_OUT_W-1:0] rsp_distance,
   output logic [5:0]            rsp_col,
   output logic [5:0]            rsp_row,
   output logic                  rsp_last
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int DW    = AW + 1;
   localparam int QW    = AW + DW;
   localparam int DEPTH = 1 << AW;
   localparam logic [DW-1:0] INF = {DW{1'b1}};

   // configuration registers
   logic [6:0] gw_ff, gh_ff;
   logic       diag_ff;
   logic [5:0] sc_ff, sr_ff, gc_ff, gr_ff;
   logic       csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff   <= 7'd64;
         gh_ff   <= 7'd64;
         diag_ff <= 1'b0;
         sc_ff   <= '0;
         sr_ff   <= '0;
         gc_ff   <= '0;
         gr_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_W:  gw_ff   <= csr_data;
            CSR_GRID_H:  gh_ff   <= csr_data;
            CSR_DIAG:    diag_ff <= csr_data[0];
            CSR_START_C: sc_ff   <= csr_data[5:0];
            CSR_START_R: sr_ff   <= csr_data[5:0];
            CSR_GOAL_C:  gc_ff   <= csr_data[5:0];
            CSR_GOAL_R:  gr_ff   <= csr_data[5:0];
            default:     ;
         endcase
      end
   end

   assign csr_hit = csr_valid && (csr_index == CSR_GRID_W || csr_index == CSR_GRID_H ||
                    csr_index == CSR_DIAG || csr_index == CSR_START_C ||
                    csr_index == CSR_START_R || csr_index == CSR_GOAL_C ||
                    csr_index == CSR_GOAL_R);

   // saturated grid size in use
   logic [EXT_W-1:0] use_w, use_h, gw9, gh9;
   assign gw9 = {2'b00, gw_ff};
   assign gh9 = {2'b00, gh_ff};
   always_comb begin
      priority if (gw_ff == '0) use_w = EXT_W'(1);
      else if (gw9 > EXT_W'(MAX_COLS)) use_w = EXT_W'(MAX_COLS);
      else use_w = gw9;
      priority if (gh_ff == '0) use_h = EXT_W'(1);
      else if (gh9 > EXT_W'(MAX_ROWS)) use_h = EXT_W'(MAX_ROWS);
      else use_h = gh9;
   end

   // start, goal and wall cells
   logic [EXT_W-1:0] sc9, sr9, gc9, gr9, wc9, wr9;
   logic [AW-1:0]    start_addr, goal_addr, wall_addr;
   logic             wall_in_range;
   assign sc9 = {3'b000, sc_ff};
   assign sr9 = {3'b000, sr_ff};
   assign gc9 = {3'b000, gc_ff};
   assign gr9 = {3'b000, gr_ff};
   assign wc9 = {3'b000, req_col};
   assign wr9 = {3'b000, req_row};
   assign start_addr = {sr9[RW-1:0], sc9[CW-1:0]};
   assign goal_addr  = {gr9[RW-1:0], gc9[CW-1:0]};
   assign wall_addr  = {wr9[RW-1:0], wc9[CW-1:0]};
   assign wall_in_range = (wc9 < EXT_W'(MAX_COLS)) && (wr9 < EXT_W'(MAX_ROWS));
   assign stat.geom_ok = (sc9 < use_w) && (gc9 < use_w) && (sr9 < use_h) && (gr9 < use_h);

   // working registers
   logic [AW-1:0] clr_cnt_ff;
   logic [AW:0]   head_ff, tail_ff;
   logic [AW-1:0] cur_addr_ff, nb_addr_ff, best_addr_ff, cursor_ff;
   logic [DW-1:0] cur_d_ff, best_d_ff;
   logic [3:0]    k_ff;
   logic          nb_ok_ff, nb_open_ff, found_ff, trace_valid_ff;

   // memories and their read registers
   logic          wall_mem [DEPTH];
   logic [DW-1:0] dist_mem [DEPTH];
   logic [QW-1:0] q_mem    [DEPTH];
   logic          wall_q_ff;
   logic [DW-1:0] dist_q_ff;
   logic [QW-1:0] q_q_ff;

   // neighbor address from current cell and offset counter
   logic [1:0]    dx, dy;
   logic [9:0]    nx, ny;
   logic [CW-1:0] cur_c;
   logic [RW-1:0] cur_r;
   logic [AW-1:0] nb_addr;
   logic          nb_ok, nb_open;
   assign dx    = nb_dx(k_ff);
   assign dy    = nb_dy(k_ff);
   assign cur_c = cur_addr_ff[CW-1:0];
   assign cur_r = cur_addr_ff[AW-1:CW];
   assign nx    = {{(10-CW){1'b0}}, cur_c} + {{8{dx[1]}}, dx};
   assign ny    = {{(10-RW){1'b0}}, cur_r} + {{8{dy[1]}}, dy};
   assign nb_addr = {ny[RW-1:0], nx[CW-1:0]};
   assign nb_ok = (k_ff != K_SELF) && (diag_ff || dx == 2'b00 || dy == 2'b00) &&
                  !nx[9] && (nx[8:0] < use_w) && !ny[9] && (ny[8:0] < use_h);
   assign nb_open = (nb_addr == start_addr) || (nb_addr == goal_addr);

   // checks on the neighbor just read
   logic          usable, enqueue;
   logic [DW-1:0] next_d;
   assign usable  = nb_ok_ff && (nb_open_ff || !wall_q_ff);
   assign next_d  = cur_d_ff + DW'(1);
   assign enqueue = cmd.nb_chk_run && usable && (dist_q_ff == INF);

   // wall map port
   logic          wall_we, wall_wd;
   logic [AW-1:0] wall_wa;
   assign wall_we = cmd.wclr_step || (cmd.wall_wr && wall_in_range);
   assign wall_wa = cmd.wclr_step ? clr_cnt_ff : wall_addr;
   assign wall_wd = cmd.wclr_step ? 1'b0 : req_wall;

   always_ff @(posedge clock) begin
      if (wall_we) wall_mem[wall_wa] <= wall_wd;
      wall_q_ff <= wall_mem[nb_addr];
   end

   // distance store port
   logic          dist_we;
   logic [AW-1:0] dist_wa, dist_ra;
   logic [DW-1:0] dist_wd;
   always_comb begin
      dist_we = 1'b1;
      dist_wa = nb_addr_ff;
      dist_wd = next_d;
      priority if (cmd.clr_step) begin
         dist_wa = clr_cnt_ff;
         dist_wd = INF;
      end else if (cmd.seed) begin
         dist_wa = start_addr;
         dist_wd = '0;
      end else begin
         dist_we = enqueue;
      end
   end
   assign dist_ra = cmd.rd_cur ? cursor_ff : nb_addr;

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_q_ff <= dist_mem[dist_ra];
   end

   // frontier queue, entries hold cell and distance
   logic          q_we;
   logic [QW-1:0] q_wd;
   assign q_we = cmd.seed || enqueue;
   assign q_wd = cmd.seed ? {start_addr, {DW{1'b0}}} : {nb_addr_ff, next_d};

   always_ff @(posedge clock) begin
      if (q_we) q_mem[tail_ff[AW-1:0]] <= q_wd;
      q_q_ff <= q_mem[head_ff[AW-1:0]];
   end

   // control counters and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         k_ff       <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (cmd.run_begin) begin
            clr_cnt_ff <= '0;
            head_ff    <= '0;
            tail_ff    <= '0;
         end else begin
            if (cmd.clr_step || cmd.wclr_step) clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (cmd.q_rd) head_ff <= head_ff + (AW+1)'(1);
            if (q_we) tail_ff <= tail_ff + (AW+1)'(1);
         end
         if (cmd.pop_latch || cmd.rd_latch) k_ff <= '0;
         else if (cmd.nb_chk_run || cmd.nb_chk_rd) k_ff <= k_ff + 4'd1;
         if (cmd.rd_latch) found_ff <= 1'b0;
         else if (cmd.nb_chk_rd && usable && (!found_ff || dist_q_ff < best_d_ff))
            found_ff <= 1'b1;
      end
   end

   // cell and neighbor payload registers
   always_ff @(posedge clock) begin
      if (cmd.pop_latch) begin
         cur_addr_ff <= q_q_ff[QW-1:DW];
         cur_d_ff    <= q_q_ff[DW-1:0];
      end else if (cmd.rd_latch) begin
         cur_addr_ff <= cursor_ff;
         cur_d_ff    <= dist_q_ff;
      end
      if (cmd.nb_addr) begin
         nb_ok_ff   <= nb_ok;
         nb_open_ff <= nb_open;
         nb_addr_ff <= nb_addr;
      end
      if (cmd.nb_chk_rd && usable && (!found_ff || dist_q_ff < best_d_ff)) begin
         best_addr_ff <= nb_addr_ff;
         best_d_ff    <= dist_q_ff;
      end
   end

   // path cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         trace_valid_ff <= 1'b0;
         cursor_ff      <= '0;
      end else begin
         if (cmd.trace_set) begin
            trace_valid_ff <= 1'b1;
            cursor_ff      <= goal_addr;
         end else if (csr_hit || cmd.wall_wr || cmd.run_begin || cmd.trace_clr) begin
            trace_valid_ff <= 1'b0;
         end else if (cmd.rd_end) begin
            if (found_ff) cursor_ff <= best_addr_ff;
            else trace_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [DIST_OUT_W-1:0] rsp_distance_ff;
   logic [5:0]            rsp_col_ff, rsp_row_ff;
   logic                  rsp_last_ff;
   logic [DW+DIST_OUT_W-1:0] d_ext;
   logic [EXT_W-1:0]      cc9, cr9;
   logic                  is_path;
   assign d_ext   = {{DIST_OUT_W{1'b0}}, cur_d_ff};
   assign cc9     = {{(EXT_W-CW){1'b0}}, cur_c};
   assign cr9     = {{(EXT_W-RW){1'b0}}, cur_r};
   assign is_path = (cmd.res == RES_PATH) || (cmd.res == RES_PATH_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         unique case (cmd.res)
            RES_GEOM:   rsp_status_ff <= ST_BAD_GEOM;
            RES_NOREAD: rsp_status_ff <= ST_NO_TRACE;
            RES_NOPATH: rsp_status_ff <= ST_NO_PATH;
            default:    rsp_status_ff <= ST_OK;
         endcase
         rsp_distance_ff <= (is_path || cmd.res == RES_RUNOK) ? d_ext[DIST_OUT_W-1:0] : '0;
         rsp_col_ff      <= is_path ? cc9[5:0] : '0;
         rsp_row_ff      <= is_path ? cr9[5:0] : '0;
         rsp_last_ff     <= (cmd.res == RES_PATH_LAST);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_last     = rsp_last_ff;

   // status to the sequencer
   assign stat.clr_done        = (clr_cnt_ff == {AW{1'b1}});
   assign stat.trace_valid     = trace_valid_ff;
   assign stat.q_empty         = (head_ff == tail_ff);
   assign stat.pop_is_goal     = (q_q_ff[QW-1:DW] == goal_addr);
   assign stat.nb_last         = (k_ff == K_LAST);
   assign stat.cursor_is_start = (cursor_ff == start_addr);
   assign stat.rsp_free        = !rsp_valid_ff || rsp_tready;

endmodule

@@ hw/rtl/grid_shortest_path_search_unit.sv @@
// grid shortest path search unit: wall writes, breadth-first search runs, path reads
// a path read step checks nine neighbors, with two store reads each; a run first clears
// all 2^AW distance-store entries (4096 at 64x64), then takes queued cells one at a time
// requests are taken one at a time; a finished response waits in an output register
// after reset a wall-map clearing pass over all 2^AW cells runs before the first request
// reset is synchronous, active high; depends on gsps_pkg, gsps_ctrl, gsps_dp
module grid_shortest_path_search_unit import gsps_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // cell_col, cell_row, wall_bit, zero fill
   input  logic [1:0]            req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // status, distance, path_col, path_row, zero fill
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type               cmd;
   stat_type              stat;
   logic [1:0]            rsp_status;
   logic [DIST_OUT_W-1:0] rsp_distance;
   logic [5:0]            rsp_col, rsp_row;

   assign csr_ready = 1'b1;

   gsps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   gsps_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_col      (req_tdata[5:0]),
      .req_row      (req_tdata[11:6]),
      .req_wall     (req_tdata[12]),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_status   (rsp_status),
      .rsp_distance (rsp_distance),
      .rsp_col      (rsp_col),
      .rsp_row      (rsp_row),
      .rsp_last     (rsp_tlast)
   );

   // response packing
   assign rsp_tdata = {6'b000000, rsp_row, rsp_col, rsp_distance, rsp_status};

endmodule
